// ----- src/cfws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfws_pkg;

   // Width of the reported slot number, fixed by the result format
   localparam int SLOT_W = 3;

   // Value returned when no entry is read
   localparam logic signed [31:0] NEG_ONE = 32'shFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN
   } state_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] item_value;
      logic signed [31:0] search_key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] read_value;
      logic [SLOT_W-1:0]  found_slot;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/cfws_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfws_mem #(
   parameter int DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic signed [31:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [31:0]              rd_data
);

   logic signed [31:0] slot_mem_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // single read port, registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/cfws_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfws_seq #(
   parameter int DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire cfws_pkg::req_type          req_data,
   output logic                            rsp_strobe,
   output cfws_pkg::rsp_type               rsp_data,
   output logic                            wr_en,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output logic signed [31:0]              wr_data,
   output logic [$clog2(DEPTH)-1:0]        rd_addr,
   input  wire logic signed [31:0]         rd_data
);

   import cfws_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type          state_ff, state_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      left_ff, left_in;
   logic signed [31:0] key_ff, key_in;
   logic [IW-1:0]      data_slot_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;
   logic               hit;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
      return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
   endfunction

   // the one comparator, reused for each entry of a scan
   assign hit = (rd_data == key_ff);

   // sequencer: next state, pointer updates and result
   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      left_in           = left_ff;
      key_in            = key_ff;
      rd_addr           = head_ff;
      wr_en             = 1'b0;
      wr_addr           = tail_ff;
      wr_data           = req_data.item_value;
      rsp_in.status     = ST_OK;
      rsp_in.read_value = NEG_ONE;
      rsp_in.found_slot = '0;
      strobe_in         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in = req_data.search_key;
               case (req_data.opcode)
                  OP_ENQUEUE: begin
                     strobe_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_slot(tail_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_DEQ;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        left_in  = count_ff;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // head entry is now in the read register
         S_DEQ: begin
            strobe_in         = 1'b1;
            rsp_in.read_value = rd_data;
            count_in          = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = next_slot(head_ff);
            end
            state_in = S_IDLE;
         end

         // one entry compared per cycle, next one fetched meanwhile
         S_SCAN: begin
            rd_addr = next_slot(data_slot_ff);
            if (hit) begin
               strobe_in         = 1'b1;
               rsp_in.found_slot = SLOT_W'(data_slot_ff);
               state_in          = S_IDLE;
            end else if (left_ff == CW'(1)) begin
               strobe_in     = 1'b1;
               rsp_in.status = ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               left_in = left_ff - CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      key_ff       <= key_in;
      data_slot_ff <= rd_addr;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- src/circular_fifo_with_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Circular FIFO of signed 32-bit values with enqueue, dequeue and key search.
// Command channel: present req_data and raise start; the transfer happens on
// a rising edge with start high and busy low. One result per command comes
// back on rsp_data, valid for exactly one cycle while rsp_strobe is high;
// the receiver must take it then, it cannot hold results off.
// Sequence per command (accept edge to result):
//   enqueue, full/empty cases, opcode three: busy stays low.
//   dequeue: busy high in S_DEQ for the one registered memory read.
//   search: busy high in S_SCAN meanwhile; one stored entry passes the
//   single comparator per cycle, from head towards tail.
// Sustained rate: 1 command per cycle for enqueue; dequeue and search
// hold off further commands while busy.
// Reset (synchronous) empties the queue: head, tail and count go to zero.
// Storage contents are not cleared; only written entries are ever read.
// A dequeue that empties the queue moves head and tail back to slot 0.
module circular_fifo_with_search_top #(
   parameter int DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cfws_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output cfws_pkg::rsp_type      rsp_data
);

   import cfws_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [IW-1:0]      rd_addr;
   logic signed [31:0] rd_data;

   cfws_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   cfws_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an accepted command either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted command neither answered nor in progress");

   // finishing a multi-cycle command always produces its result
   a_busy_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // a result is shown only while the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // no write into storage while a dequeue or search is in progress
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("storage written during a multi-cycle command");

endmodule

`default_nettype wire
